### rtl/mppt_charge_controller_macros.svh
// Assertion macros shared by the charge controller checker.
`ifndef MPPT_CHARGE_CONTROLLER_MACROS_SVH
`define MPPT_CHARGE_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MPPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MPPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mppt_cc_pkg.sv
// Types, widths and constants for the MPPT charge controller.
package mppt_cc_pkg;

    // ADC conversion width and the derived measurement widths
    localparam int SAMPLE_BITS = 10;
    localparam int V_W         = SAMPLE_BITS;        // voltage count
    localparam int I_W         = SAMPLE_BITS + 1;    // current: signed count difference
    localparam int DU_W        = SAMPLE_BITS + 1;    // vin change
    localparam int DI_W        = SAMPLE_BITS + 2;    // iin change
    localparam int N_W         = DI_W + V_W + 2;     // cross-multiplied conductance sum

    // Register widths
    localparam int LEVEL_W = 10;
    localparam int DUTY_W  = 8;
    localparam int CMP_W   = ((SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W) + 2;

    // APB port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Reset values
    localparam logic [LEVEL_W-1:0] CHARGE_LEVEL_RST = LEVEL_W'(744);
    localparam logic [LEVEL_W-1:0] LOW_BATT_RST     = LEVEL_W'(579);
    localparam logic [LEVEL_W-1:0] TAPER_RST        = LEVEL_W'(0);
    localparam logic [DUTY_W-1:0]  PWM_TOP_RST      = DUTY_W'(159);
    localparam logic [DUTY_W-1:0]  DUTY_RST         = DUTY_W'(15);

    // Register map (word index)
    typedef enum logic [1:0] {
        REG_CHARGE_LEVEL = 2'd0,
        REG_LOW_BATT     = 2'd1,
        REG_TAPER        = 2'd2,
        REG_PWM_TOP      = 2'd3
    } reg_addr_t;

    // Charge mode
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_CHARGE = 2'd1,
        MODE_CV     = 2'd2
    } mode_t;

    // Requested duty move
    typedef enum logic [1:0] {
        DIR_HOLD = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } duty_dir_t;

    // Input-side measurements seen by the tracker
    typedef struct packed {
        logic        [V_W-1:0] vin_previous;
        logic        [V_W-1:0] vin_present;
        logic signed [I_W-1:0] iin_previous;
        logic signed [I_W-1:0] iin_present;
    } meas_t;

endpackage

### rtl/mppt_charge_controller.sv
// MPPT charge controller: an input beat passes the input register, then the
// state/result register, on its way to a result beat; throughput one beat per
// cycle while the result side is not stalled, with two small multipliers.
// Each sample or tick beat yields one result beat.
// Reset (rst_n, async, low): registers to their defaults, measurements to 0,
// duty to 15, mode idle, both pipeline slots empty.
module mppt_charge_controller
    import mppt_cc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   kind,
    input  logic [1:0]             channel,
    input  logic [SAMPLE_BITS-1:0] sample,
    // result channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [DUTY_W-1:0]      duty,
    output logic                   charging,
    output logic                   voltage_hold,
    // APB configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    // configuration registers
    logic [LEVEL_W-1:0] charge_level_reg;
    logic [LEVEL_W-1:0] low_batt_reg;
    logic [LEVEL_W-1:0] taper_reg;
    logic [DUTY_W-1:0]  pwm_top_reg;

    // input stage
    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_kind_reg;
    logic [1:0]             s1_channel_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;

    // state, which also forms the result
    logic                  out_valid_reg, out_valid_next;
    logic [V_W-1:0]        vin_prev_reg, vin_prev_next;
    logic [V_W-1:0]        vin_pres_reg, vin_pres_next;
    logic signed [I_W-1:0] iin_prev_reg, iin_prev_next;
    logic signed [I_W-1:0] iin_pres_reg, iin_pres_next;
    logic [V_W-1:0]        vout_reg, vout_next;
    logic signed [I_W-1:0] iout_reg, iout_next;
    logic [DUTY_W-1:0]     duty_reg, duty_next;
    mode_t                 mode_reg, mode_next;

    logic                  accept;
    logic                  advance;
    logic                  cfg_write;
    reg_addr_t             cfg_addr;
    meas_t                 meas;
    duty_dir_t             mppt_dir;
    duty_dir_t             dir;
    logic [DUTY_W-1:0]     duty_clamped;
    logic [CMP_W-1:0]      vout_ext;
    logic [CMP_W-1:0]      charge_level_ext;
    logic [CMP_W-1:0]      low_batt_ext;
    logic signed [CMP_W-1:0] iout_ext;
    logic signed [CMP_W-1:0] taper_ext;
    logic                  above_taper;
    duty_dir_t             cv_dir;

    // handshake: the input slot moves on when the result slot is free or leaving
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    assign duty         = duty_reg;
    assign charging     = (mode_reg == MODE_CHARGE) || (mode_reg == MODE_CV);
    assign voltage_hold = (mode_reg == MODE_CV);

    // APB access
    assign pready    = 1'b1;
    assign cfg_addr  = reg_addr_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_addr)
            REG_CHARGE_LEVEL: prdata = PDATA_W'(charge_level_reg);
            REG_LOW_BATT:     prdata = PDATA_W'(low_batt_reg);
            REG_TAPER:        prdata = PDATA_W'(taper_reg);
            REG_PWM_TOP:      prdata = PDATA_W'(pwm_top_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charge_level_reg <= CHARGE_LEVEL_RST;
            low_batt_reg     <= LOW_BATT_RST;
            taper_reg        <= TAPER_RST;
            pwm_top_reg      <= PWM_TOP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                REG_CHARGE_LEVEL: charge_level_reg <= pwdata[LEVEL_W-1:0];
                REG_LOW_BATT:     low_batt_reg     <= pwdata[LEVEL_W-1:0];
                REG_TAPER:        taper_reg        <= pwdata[LEVEL_W-1:0];
                REG_PWM_TOP:      pwm_top_reg      <= pwdata[DUTY_W-1:0];
            endcase
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg    <= kind;
            s1_channel_reg <= channel;
            s1_sample_reg  <= sample;
        end
    end

    // MPPT decision on present measurements
    assign meas.vin_previous = vin_prev_reg;
    assign meas.vin_present  = vin_pres_reg;
    assign meas.iin_previous = iin_prev_reg;
    assign meas.iin_present  = iin_pres_reg;

    mppt_cc_tracker u_tracker
    (
        .meas (meas),
        .dir  (mppt_dir)
    );

    // comparisons on common widths
    assign vout_ext         = CMP_W'(vout_reg);
    assign charge_level_ext = CMP_W'(charge_level_reg);
    assign low_batt_ext     = CMP_W'(low_batt_reg);
    assign iout_ext         = CMP_W'(iout_reg);
    assign taper_ext        = $signed(CMP_W'(taper_reg));
    assign above_taper      = iout_ext > taper_ext;
    assign duty_clamped     = (duty_reg > pwm_top_reg) ? pwm_top_reg : duty_reg;

    // CV step direction toward the charge level
    always_comb
    begin
        cv_dir = DIR_HOLD;
        if (vout_ext < charge_level_ext)
            cv_dir = DIR_UP;
        else if (vout_ext > charge_level_ext)
            cv_dir = DIR_DOWN;
    end

    // next state for one beat
    always_comb
    begin
        vin_prev_next  = vin_prev_reg;
        vin_pres_next  = vin_pres_reg;
        iin_prev_next  = iin_prev_reg;
        iin_pres_next  = iin_pres_reg;
        vout_next      = vout_reg;
        iout_next      = iout_reg;
        duty_next      = duty_reg;
        mode_next      = mode_reg;
        dir            = DIR_HOLD;
        out_valid_next = out_valid_reg;
        s1_valid_next  = s1_valid_reg;

        if (advance)
        begin
            if (!s1_kind_reg)
            begin
                // sample beat
                unique case (s1_channel_reg)
                    2'd0:
                    begin
                        vin_prev_next = vin_pres_reg;
                        vin_pres_next = s1_sample_reg;
                    end
                    2'd1:
                    begin
                        iin_prev_next = iin_pres_reg;
                        iin_pres_next = $signed({1'b0, vin_pres_reg})
                                      - $signed({1'b0, s1_sample_reg});
                    end
                    2'd2:
                        vout_next = s1_sample_reg;
                    2'd3:
                        iout_next = $signed({1'b0, s1_sample_reg})
                                  - $signed({1'b0, vout_reg});
                endcase
            end
            else
            begin
                // tick beat: mode machine
                unique case (mode_reg)
                    MODE_CV:
                    begin
                        if (above_taper)
                            dir = cv_dir;
                        else
                            mode_next = MODE_IDLE;
                    end
                    MODE_CHARGE:
                    begin
                        if (vout_ext >= charge_level_ext)
                        begin
                            mode_next = MODE_CV;
                            if (above_taper)
                                dir = cv_dir;
                            else
                                mode_next = MODE_IDLE;
                        end
                        else
                            dir = mppt_dir;
                    end
                    default:
                    begin
                        mode_next = (vout_ext < low_batt_ext) ? MODE_CHARGE : MODE_IDLE;
                        dir       = mppt_dir;
                    end
                endcase

                // saturating duty move
                duty_next = duty_clamped;
                unique case (dir)
                    DIR_UP:
                        if (duty_clamped < pwm_top_reg)
                            duty_next = duty_clamped + DUTY_W'(1);
                    DIR_DOWN:
                        if (duty_clamped != '0)
                            duty_next = duty_clamped - DUTY_W'(1);
                    default:
                        duty_next = duty_clamped;
                endcase
            end
        end

        // slot occupancy
        if (advance)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            vin_prev_reg  <= '0;
            vin_pres_reg  <= '0;
            iin_prev_reg  <= '0;
            iin_pres_reg  <= '0;
            vout_reg      <= '0;
            iout_reg      <= '0;
            duty_reg      <= DUTY_RST;
            mode_reg      <= MODE_IDLE;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            vin_prev_reg  <= vin_prev_next;
            vin_pres_reg  <= vin_pres_next;
            iin_prev_reg  <= iin_prev_next;
            iin_pres_reg  <= iin_pres_next;
            vout_reg      <= vout_next;
            iout_reg      <= iout_next;
            duty_reg      <= duty_next;
            mode_reg      <= mode_next;
        end
    end

endmodule

### rtl/mppt_cc_tracker.sv
// Incremental-conductance MPPT decision: which way to move the duty.
module mppt_cc_tracker
    import mppt_cc_pkg::*;
(
    input  meas_t     meas,
    output duty_dir_t dir
);

    logic signed [DU_W-1:0] du;
    logic signed [DI_W-1:0] di;
    logic signed [N_W-1:0]  prod_a;
    logic signed [N_W-1:0]  prod_b;
    logic signed [N_W-1:0]  n_sum;
    logic                   n_zero;

    // Changes since the previous samples
    assign du = $signed({1'b0, meas.vin_present}) - $signed({1'b0, meas.vin_previous});
    assign di = $signed(DI_W'(meas.iin_present)) - $signed(DI_W'(meas.iin_previous));

    // dI/dV + I/V sign test, cross-multiplied: n = di*v + i*du
    assign prod_a = N_W'(di * $signed({1'b0, meas.vin_present}));
    assign prod_b = N_W'(meas.iin_present * du);
    assign n_sum  = prod_a + prod_b;
    assign n_zero = (n_sum == '0);

    // Decision; sign of n*du is the xor of the two signs
    always_comb
    begin
        dir = DIR_HOLD;
        if (du == '0)
        begin
            if (!di[DI_W-1] && (di != '0))
                dir = DIR_DOWN;
            else if (di[DI_W-1])
                dir = DIR_UP;
        end
        else if ((meas.vin_present != '0) && !n_zero)
        begin
            if (n_sum[N_W-1] == du[DU_W-1])
                dir = DIR_DOWN;
            else
                dir = DIR_UP;
        end
    end

endmodule

### rtl/mppt_cc_checker.sv
// Port-level checks for the MPPT charge controller, bound to the top level.
`include "mppt_charge_controller_macros.svh"

module mppt_cc_checker
    import mppt_cc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [DUTY_W-1:0]      duty,
    input logic                   charging,
    input logic                   voltage_hold,
    input logic                   psel,
    input logic                   penable,
    input logic                   pwrite,
    input logic [PADDR_W-1:0]     paddr,
    input logic [PDATA_W-1:0]     pwdata,
    input logic [PDATA_W-1:0]     prdata,
    input logic                   pready
);

    // CV mode is part of a charge cycle
    `MPPT_ASSERT_NOW(a_hold_in_charge, out_valid, !voltage_hold || charging, "CV without charging")

    // a stalled result beat stays put
    `MPPT_ASSERT_NEXT(a_result_held, out_valid && out_stall,
        out_valid && $stable(duty) && $stable(charging) && $stable(voltage_hold),
        "stalled result changed")

    // the input side only backs up behind a stalled result
    `MPPT_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stall without output stall")

    // a pwm_top write reads back
    `MPPT_ASSERT_NOW(a_top_readback,
        (psel && penable && pwrite && pready && (paddr[3:2] == REG_PWM_TOP)) ##1
            (paddr[3:2] == REG_PWM_TOP),
        prdata[DUTY_W-1:0] == $past(pwdata[DUTY_W-1:0]), "pwm_top readback mismatch")

endmodule

bind mppt_charge_controller mppt_cc_checker u_mppt_cc_checker (.*);

### tb/tb_mppt_charge_controller.sv
// Self-checking testbench for the MPPT charge controller: ADC/tick beats against a predictor.
`timescale 1ns / 1ps

module tb_mppt_charge_controller
    import mppt_cc_pkg::*;
();

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int RANDOM_BEATS = 1800;
    localparam int N_PHASES     = 9;
    localparam int PHASE_BEATS  = RANDOM_BEATS / N_PHASES;
    localparam int MAX_REPORTS  = 40;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;

    // Beat kinds and ADC channel codes
    localparam logic       KIND_SAMPLE   = 1'b0;
    localparam logic       KIND_TICK     = 1'b1;
    localparam logic [1:0] CH_VIN        = 2'd0;
    localparam logic [1:0] CH_VIN_SENSE  = 2'd1;
    localparam logic [1:0] CH_VOUT       = 2'd2;
    localparam logic [1:0] CH_VOUT_SENSE = 2'd3;

    typedef struct {
        logic                   kind;
        logic [1:0]             channel;
        logic [SAMPLE_BITS-1:0] sample;
    } in_beat_t;

    typedef struct {
        logic [DUTY_W-1:0] duty;
        logic              charging;
        logic              voltage_hold;
    } status_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // DUT ports
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   kind     = 1'b0;
    logic [1:0]             channel  = 2'd0;
    logic [SAMPLE_BITS-1:0] sample   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [DUTY_W-1:0]      duty;
    logic                   charging;
    logic                   voltage_hold;
    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [PADDR_W-1:0]     paddr   = '0;
    logic [PDATA_W-1:0]     pwdata  = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    mppt_charge_controller u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .channel      (channel),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .duty         (duty),
        .charging     (charging),
        .voltage_hold (voltage_hold),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Predictor copy of the registers
    logic [LEVEL_W-1:0] cfg_charge_level = CHARGE_LEVEL_RST;
    logic [LEVEL_W-1:0] cfg_low_batt     = LOW_BATT_RST;
    logic [LEVEL_W-1:0] cfg_taper        = TAPER_RST;
    logic [DUTY_W-1:0]  cfg_pwm_top      = PWM_TOP_RST;

    // Predictor copy of the measurements and charge state
    logic        [V_W-1:0]    m_vin_prev = '0;
    logic        [V_W-1:0]    m_vin_cur  = '0;
    logic        [V_W-1:0]    m_vout     = '0;
    logic signed [I_W-1:0]    m_iin_prev = '0;
    logic signed [I_W-1:0]    m_iin_cur  = '0;
    logic signed [I_W-1:0]    m_iout     = '0;
    logic        [DUTY_W-1:0] m_duty     = DUTY_RST;
    mode_t                    m_mode     = MODE_IDLE;

    in_beat_t beats_pending[$];
    status_t  status_due[$];

    int fail_count  = 0;
    int cycle_count = 0;
    int beats_made  = 0;

    // Stimulus walk state
    int st_vin  = 512;
    int st_vout = 600;

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch %s: got %0d want %0d", $time, what, got, want);
    endtask

    // Saturating one-step duty move
    function automatic void move_duty(input duty_dir_t dir);
        if (dir == DIR_UP)
            m_duty = (m_duty < cfg_pwm_top) ? m_duty + 1'b1 : cfg_pwm_top;
        else if (dir == DIR_DOWN && m_duty != '0)
            m_duty = m_duty - 1'b1;
    endfunction

    // Incremental conductance: sign of (di*v + i*du) taken against the sign of du
    function automatic duty_dir_t mppt_dir();
        int du;
        int di;
        int n;
        du = int'(m_vin_cur) - int'(m_vin_prev);
        di = int'(m_iin_cur) - int'(m_iin_prev);
        if (du == 0)
        begin
            if (di > 0)
                return DIR_DOWN;
            if (di < 0)
                return DIR_UP;
            return DIR_HOLD;
        end
        if (m_vin_cur == '0)
            return DIR_HOLD;
        n = di * int'(m_vin_cur) + int'(m_iin_cur) * du;
        if (n == 0)
            return DIR_HOLD;
        if ((n > 0) == (du > 0))
            return DIR_DOWN;
        return DIR_UP;
    endfunction

    // Constant-voltage step, or back to idle once the current has tapered
    function automatic void cv_step();
        if (int'(m_iout) > int'(cfg_taper))
        begin
            if (m_vout < cfg_charge_level)
                move_duty(DIR_UP);
            else if (m_vout > cfg_charge_level)
                move_duty(DIR_DOWN);
        end
        else
            m_mode = MODE_IDLE;
    endfunction

    // Apply one accepted beat to the predictor, return the status it should report
    function automatic status_t charger_advance(input in_beat_t b);
        status_t s;
        if (b.kind == KIND_SAMPLE)
        begin
            unique case (b.channel)
                CH_VIN:
                begin
                    m_vin_prev = m_vin_cur;
                    m_vin_cur  = b.sample;
                end
                CH_VIN_SENSE:
                begin
                    m_iin_prev = m_iin_cur;
                    m_iin_cur  = I_W'(int'(m_vin_cur) - int'(b.sample));
                end
                CH_VOUT:
                    m_vout = b.sample;
                default:
                    m_iout = I_W'(int'(b.sample) - int'(m_vout));
            endcase
        end
        else
        begin
            if (m_duty > cfg_pwm_top)
                m_duty = cfg_pwm_top;
            unique case (m_mode)
                MODE_CV:
                    cv_step();
                MODE_CHARGE:
                begin
                    if (m_vout >= cfg_charge_level)
                    begin
                        m_mode = MODE_CV;
                        cv_step();
                    end
                    else
                        move_duty(mppt_dir());
                end
                default:
                begin
                    m_mode = MODE_IDLE;
                    if (m_vout < cfg_low_batt)
                        m_mode = MODE_CHARGE;
                    move_duty(mppt_dir());
                end
            endcase
        end
        s.duty         = m_duty;
        s.charging     = (m_mode == MODE_CHARGE) || (m_mode == MODE_CV);
        s.voltage_hold = (m_mode == MODE_CV);
        return s;
    endfunction

    // Sender gap: mostly none or short, some long, occasional gap-free stretches
    int calm_left = 0;

    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Input driver
    in_beat_t on_bus;
    int       gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                status_due.push_back(charger_advance(on_bus));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0 || beats_pending.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    on_bus = beats_pending.pop_front();
                    in_valid <= 1'b1;
                    kind     <= on_bus.kind;
                    channel  <= on_bus.channel;
                    sample   <= on_bus.sample;
                    gap_left = pick_gap();
                end
            end
        end
    end

    // Result-side stall: short bursts, some long ones, stretches with none
    int stall_left = 0;
    int clear_left = 0;

    always @(posedge clk)
    begin : stall_gen
        int r;
        if (!rst_n)
            out_stall <= 1'b0;
        else if (clear_left > 0)
        begin
            clear_left--;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                clear_left = $urandom_range(0, 2);
                out_stall <= 1'b0;
            end
            else if (r < 59)
            begin
                clear_left = $urandom_range(20, 80);
                out_stall <= 1'b0;
            end
            else if (r < 92)
            begin
                stall_left = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = $urandom_range(9, 39);
                out_stall <= 1'b1;
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin : result_check
        status_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (status_due.size() == 0)
                report_mismatch("result beat with nothing due", 1, 0);
            else
            begin
                want = status_due.pop_front();
                if (duty !== want.duty)
                    report_mismatch("duty", duty, want.duty);
                if (charging !== want.charging)
                    report_mismatch("charging", charging, want.charging);
                if (voltage_hold !== want.voltage_hold)
                    report_mismatch("voltage_hold", voltage_hold, want.voltage_hold);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_mppt_charge_controller NOT OK");
            $finish;
        end
    end

    // APB write: setup then access; junk in the unused upper data bits
    task automatic cfg_write(input reg_addr_t idx, input int value);
        logic [PDATA_W-1:0] word;
        word = $urandom();
        if (idx == REG_PWM_TOP)
            word[DUTY_W-1:0] = DUTY_W'(value);
        else
            word[LEVEL_W-1:0] = LEVEL_W'(value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        unique case (idx)
            REG_CHARGE_LEVEL: cfg_charge_level = word[LEVEL_W-1:0];
            REG_LOW_BATT:     cfg_low_batt     = word[LEVEL_W-1:0];
            REG_TAPER:        cfg_taper        = word[LEVEL_W-1:0];
            default:          cfg_pwm_top      = word[DUTY_W-1:0];
        endcase
    endtask

    task automatic apply_settings(input int charge_lvl, input int low_lvl,
                                  input int taper_lvl, input int top);
        cfg_write(REG_PWM_TOP, top);
        cfg_write(REG_TAPER, taper_lvl);
        cfg_write(REG_LOW_BATT, low_lvl);
        cfg_write(REG_CHARGE_LEVEL, charge_lvl);
    endtask

    // Block until all beats are in, all results are back, then cover the pipeline
    task automatic wait_drained();
        do
            @(negedge clk);
        while (beats_pending.size() != 0 || in_valid || status_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    function automatic int clamp_count(input int v);
        if (v < 0)
            return 0;
        if (v > SAMPLE_MAX)
            return SAMPLE_MAX;
        return v;
    endfunction

    function automatic int jitter(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic push_beat(input logic k, input logic [1:0] ch, input int s);
        in_beat_t b;
        b.kind    = k;
        b.channel = ch;
        b.sample  = SAMPLE_BITS'(s);
        beats_pending.push_back(b);
        beats_made++;
    endtask

    task automatic push_tick();
        push_beat(KIND_TICK, 2'($urandom()), $urandom_range(0, SAMPLE_MAX));
    endtask

    // One measurement round (vin, vin sense, vout, vout sense) and a tick,
    // sometimes with parts missing or a stray beat thrown in
    task automatic push_frame();
        int r;
        int cur;
        int s;
        r = $urandom_range(0, 99);
        // vin: often unchanged so the equal-voltage branch is taken
        if (r >= 25)
        begin
            if (r < 90)
                st_vin = clamp_count(st_vin + jitter(8));
            else
                st_vin = $urandom_range(0, SAMPLE_MAX);
        end
        if ($urandom_range(0, 9) != 0)
            push_beat(KIND_SAMPLE, CH_VIN, st_vin);
        // vin after sense: drop set by the input current
        if ($urandom_range(0, 99) < 85)
            s = clamp_count(st_vin - int'($urandom_range(0, 60)));
        else
            s = $urandom_range(0, SAMPLE_MAX);
        if ($urandom_range(0, 9) != 0)
            push_beat(KIND_SAMPLE, CH_VIN_SENSE, s);
        // vout: steered around both thresholds
        r = $urandom_range(0, 99);
        if (r < 35)
            st_vout = clamp_count(int'(cfg_charge_level) + jitter(3));
        else if (r < 55)
            st_vout = clamp_count(int'(cfg_low_batt) + jitter(3));
        else if (r < 88)
            st_vout = clamp_count(st_vout + jitter(6));
        else
            st_vout = $urandom_range(0, SAMPLE_MAX);
        if ($urandom_range(0, 9) != 0)
            push_beat(KIND_SAMPLE, CH_VOUT, st_vout);
        // vout after sense: current mostly near the taper level
        r = $urandom_range(0, 99);
        if (r < 55)
            cur = int'(cfg_taper) + jitter(3);
        else if (r < 85)
            cur = jitter(120);
        else
            cur = int'($urandom_range(0, SAMPLE_MAX)) - st_vout;
        if ($urandom_range(0, 9) != 0)
            push_beat(KIND_SAMPLE, CH_VOUT_SENSE, clamp_count(st_vout + cur));
        if ($urandom_range(0, 19) != 0)
            push_tick();
        // stray beat
        if ($urandom_range(0, 9) == 0)
            push_beat(1'($urandom()), 2'($urandom()), $urandom_range(0, SAMPLE_MAX));
    endtask

    task automatic push_random(input int count);
        int stop_at;
        stop_at = beats_made + count;
        while (beats_made < stop_at)
            push_frame();
    endtask

    // Field extremes, both MPPT branches, zero vin, mode walk idle -> charge -> CV -> idle
    task automatic push_directed();
        push_beat(KIND_SAMPLE, CH_VIN, SAMPLE_MAX);
        push_beat(KIND_SAMPLE, CH_VIN_SENSE, 0);
        push_beat(KIND_SAMPLE, CH_VOUT, SAMPLE_MAX);
        push_beat(KIND_SAMPLE, CH_VOUT_SENSE, 0);
        push_beat(KIND_TICK, CH_VOUT_SENSE, SAMPLE_MAX);
        // unchanged vin, falling current: duty up
        push_beat(KIND_SAMPLE, CH_VIN, SAMPLE_MAX);
        push_beat(KIND_SAMPLE, CH_VIN_SENSE, SAMPLE_MAX);
        push_beat(KIND_TICK, CH_VIN, 0);
        // unchanged vin, rising current: duty down
        push_beat(KIND_SAMPLE, CH_VIN_SENSE, 0);
        push_beat(KIND_TICK, CH_VIN_SENSE, 0);
        // vin drops to zero: hold
        push_beat(KIND_SAMPLE, CH_VIN, 0);
        push_beat(KIND_SAMPLE, CH_VIN_SENSE, 0);
        push_beat(KIND_TICK, CH_VOUT, SAMPLE_MAX);
        // low battery with full output current: start charging
        push_beat(KIND_SAMPLE, CH_VOUT, 0);
        push_beat(KIND_SAMPLE, CH_VOUT_SENSE, SAMPLE_MAX);
        push_beat(KIND_TICK, CH_VIN, SAMPLE_MAX);
        // vout at full scale: enter CV and step down
        push_beat(KIND_SAMPLE, CH_VOUT, SAMPLE_MAX);
        push_beat(KIND_TICK, CH_VIN, 0);
        push_beat(KIND_TICK, CH_VOUT_SENSE, 0);
        // current tapered to negative: back to idle
        push_beat(KIND_SAMPLE, CH_VOUT_SENSE, 0);
        push_beat(KIND_TICK, CH_VIN_SENSE, SAMPLE_MAX);
        push_beat(KIND_TICK, CH_VOUT, 0);
    endtask

    // Register settings per phase; phase 0 runs on reset values
    task automatic apply_phase(input int p);
        unique case (p)
            1: apply_settings(1023, 1023, 1023, 255);
            2: apply_settings(0, 0, 0, 1);
            3: apply_settings(744, 579, 0, 159);
            4: apply_settings(600, 620, 5, 4);
            5: apply_settings($urandom_range(500, 900), $urandom_range(300, 700),
                              $urandom_range(0, 40), 0);
            6: apply_settings(512, 300, 20, 2);
            7: apply_settings($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                              $urandom_range(0, 60), $urandom_range(1, 255));
            default: apply_settings(800, 780, 2, $urandom_range(1, 8));
        endcase
    endtask

    // Sequence: reset, then phases separated by full drains and register writes
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        push_directed();
        push_random(PHASE_BEATS);
        wait_drained();
        for (int p = 1; p < N_PHASES; p++)
        begin
            apply_phase(p);
            push_random(PHASE_BEATS);
            wait_drained();
        end
        if (fail_count == 0)
            $display("tb_mppt_charge_controller OK");
        else
            $display("tb_mppt_charge_controller NOT OK");
        $finish;
    end

endmodule
